// ----- hdl/assert_macros.svh -----
// Assertion macros used by the tuner controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Condition in this cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/fla_pkg.sv -----
// Types and constants of the frequency ladder autotuner.
`timescale 1ns / 1ps
`default_nettype none
package fla_pkg;

   localparam int LADDER_WORDS = 3;
   localparam int CSR_ADDR_W   = 6;
   localparam int CSR_DATA_W   = 64;

   // register indexes (byte address = 8 * index)
   localparam logic [2:0] REG_LADDER_0    = 3'd0;
   localparam logic [2:0] REG_LADDER_1    = 3'd1;
   localparam logic [2:0] REG_LADDER_2    = 3'd2;
   localparam logic [2:0] REG_WARMUP      = 3'd3;
   localparam logic [2:0] REG_CLIMB_IVL   = 3'd4;
   localparam logic [2:0] REG_COOLDOWN    = 3'd5;
   localparam logic [2:0] REG_STABLE_LIM  = 3'd6;
   localparam logic [2:0] REG_UNSTABLE_LIM = 3'd7;

   localparam logic [15:0] WARMUP_RST     = 16'd300;
   localparam logic [15:0] CLIMB_IVL_RST  = 16'd600;
   localparam logic [15:0] COOLDOWN_RST   = 16'd60;
   localparam logic [13:0] STABLE_LIM_RST = 14'd100;
   localparam logic [13:0] UNSTABLE_LIM_RST = 14'd300;

   localparam logic [1:0] MODE_OFF     = 2'd0;
   localparam logic [1:0] MODE_WARMUP  = 2'd1;
   localparam logic [1:0] MODE_CLIMB   = 2'd2;
   localparam logic [1:0] MODE_BACKOFF = 2'd3;

   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_RESUMED   = 3'd1;
   localparam logic [2:0] EV_UP        = 3'd2;
   localparam logic [2:0] EV_CEILING   = 3'd3;
   localparam logic [2:0] EV_DOWN      = 3'd4;
   localparam logic [2:0] EV_FLOOR     = 3'd5;
   localparam logic [2:0] EV_WARM_DONE = 3'd6;
   localparam logic [2:0] EV_COOL_DONE = 3'd7;

   typedef struct packed {
      logic [LADDER_WORDS-1:0][63:0] ladder;
      logic [15:0] warmup_ticks;
      logic [15:0] climb_interval_ticks;
      logic [15:0] cooldown_ticks;
      logic [13:0] stable_error_limit;
      logic [13:0] unstable_error_limit;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic scan_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ----- hdl/fla_csr.sv -----
// Configuration register file with APB-style access.
`timescale 1ns / 1ps
`default_nettype none
module fla_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [fla_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [fla_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [fla_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output fla_pkg::cfg_type                     cfg
);

   fla_pkg::cfg_type cfg_ff;
   fla_pkg::cfg_type cfg_in;
   logic [2:0]       reg_sel;
   logic             wr_en;

   assign reg_sel    = csr_paddr[5:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            fla_pkg::REG_LADDER_0:     cfg_in.ladder[0] = csr_pwdata;
            fla_pkg::REG_LADDER_1:     cfg_in.ladder[1] = csr_pwdata;
            fla_pkg::REG_LADDER_2:     cfg_in.ladder[2] = csr_pwdata;
            fla_pkg::REG_WARMUP:       cfg_in.warmup_ticks = csr_pwdata[15:0];
            fla_pkg::REG_CLIMB_IVL:    cfg_in.climb_interval_ticks = csr_pwdata[15:0];
            fla_pkg::REG_COOLDOWN:     cfg_in.cooldown_ticks = csr_pwdata[15:0];
            fla_pkg::REG_STABLE_LIM:   cfg_in.stable_error_limit = csr_pwdata[13:0];
            fla_pkg::REG_UNSTABLE_LIM: cfg_in.unstable_error_limit = csr_pwdata[13:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ladder               <= '0;
         cfg_ff.warmup_ticks         <= fla_pkg::WARMUP_RST;
         cfg_ff.climb_interval_ticks <= fla_pkg::CLIMB_IVL_RST;
         cfg_ff.cooldown_ticks       <= fla_pkg::COOLDOWN_RST;
         cfg_ff.stable_error_limit   <= fla_pkg::STABLE_LIM_RST;
         cfg_ff.unstable_error_limit <= fla_pkg::UNSTABLE_LIM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         fla_pkg::REG_LADDER_0:     csr_prdata = cfg_ff.ladder[0];
         fla_pkg::REG_LADDER_1:     csr_prdata = cfg_ff.ladder[1];
         fla_pkg::REG_LADDER_2:     csr_prdata = cfg_ff.ladder[2];
         fla_pkg::REG_WARMUP:       csr_prdata = 64'(cfg_ff.warmup_ticks);
         fla_pkg::REG_CLIMB_IVL:    csr_prdata = 64'(cfg_ff.climb_interval_ticks);
         fla_pkg::REG_COOLDOWN:     csr_prdata = 64'(cfg_ff.cooldown_ticks);
         fla_pkg::REG_STABLE_LIM:   csr_prdata = 64'(cfg_ff.stable_error_limit);
         fla_pkg::REG_UNSTABLE_LIM: csr_prdata = 64'(cfg_ff.unstable_error_limit);
         default:                   csr_prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

// ----- hdl/fla_dp.sv -----
// Datapath: input capture, serial ladder scan, tuner state and result register.
`timescale 1ns / 1ps
`default_nettype none
module fla_dp #(
   parameter int MAX_PRESETS   = 12,
   parameter int STABLE_WINDOW = 3
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  fla_pkg::cfg_type        cfg,
   input  fla_pkg::cmd_type        cmd,
   output fla_pkg::status_type     status,
   input  wire logic               req_enabled,
   input  wire logic               req_self_test_active,
   input  wire logic               req_asic_ready,
   input  wire logic               req_voltage_throttling,
   input  wire logic               req_thermal_throttling,
   input  wire logic [13:0]        req_error_rate,
   input  wire logic [15:0]        req_current_mhz,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_freq_write,
   output logic [15:0]             rsp_freq_mhz,
   output logic                    rsp_tuned_write,
   output logic [15:0]             rsp_tuned_mhz,
   output logic [1:0]              rsp_mode,
   output logic [2:0]              rsp_event_res
);

   localparam int IDX_W = (MAX_PRESETS > 2) ? $clog2(MAX_PRESETS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PRESETS - 1);
   localparam logic [1:0] WINDOW = 2'(STABLE_WINDOW);

   logic [15:0] preset_arr [MAX_PRESETS];

   for (genvar g = 0; g < MAX_PRESETS; g++) begin : g_preset
      assign preset_arr[g] = cfg.ladder[g / 4][16 * (g % 4) +: 16];
   end

   // captured tick
   logic        en_ff, self_test_ff, asic_rdy_ff, throttled_ff;
   logic [13:0] err_ff;
   logic [15:0] cur_ff;

   // scan results
   logic [IDX_W-1:0] scan_idx_ff;
   logic             scan_end_ff, stop_ff;
   logic             have_floor_ff, have_below_ff, have_next_ff;
   logic [15:0]      floor_val_ff, below_val_ff, next_val_ff, ceil_ff;
   logic [15:0]      preset;
   logic             live;

   // tuner state
   logic [1:0]  mode_ff, mode_in;
   logic        was_on_ff, was_on_in;
   logic [15:0] tim_ff, tim_in;
   logic [15:0] tsc_ff, tsc_in;
   logic [1:0]  sc_ff, sc_in;
   logic [15:0] stored_ff, stored_in;

   // result register
   logic        rsp_valid_ff;
   logic        fw_ff, fw_in;
   logic [15:0] fmhz_ff, fmhz_in;
   logic        tw_ff, tw_in;
   logic [1:0]  mode_out_ff;
   logic [2:0]  ev_ff, ev_in;

   assign preset = preset_arr[scan_idx_ff];
   assign live   = !scan_end_ff && (preset != 16'd0);

   assign status.scan_last = (scan_idx_ff == IDX_LAST);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         en_ff        <= req_enabled;
         self_test_ff <= req_self_test_active;
         asic_rdy_ff  <= req_asic_ready;
         throttled_ff <= req_voltage_throttling || req_thermal_throttling;
         err_ff       <= req_error_rate;
         cur_ff       <= req_current_mhz;
      end
   end

   // walk one preset per cycle; the ladder ends at the first zero
   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         scan_idx_ff   <= '0;
         scan_end_ff   <= 1'b0;
         stop_ff       <= 1'b0;
         have_floor_ff <= 1'b0;
         have_below_ff <= 1'b0;
         have_next_ff  <= 1'b0;
         ceil_ff       <= '0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         if (preset == 16'd0) begin
            scan_end_ff <= 1'b1;
         end
         if (live) begin
            if (preset > ceil_ff) begin
               ceil_ff <= preset;
            end
            if (!stop_ff) begin
               if (preset <= cur_ff) begin
                  below_val_ff  <= floor_val_ff;
                  have_below_ff <= have_floor_ff;
                  floor_val_ff  <= preset;
                  have_floor_ff <= 1'b1;
               end else begin
                  stop_ff      <= 1'b1;
                  next_val_ff  <= preset;
                  have_next_ff <= 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      logic [15:0] resumed;
      resumed   = stored_ff;
      mode_in   = mode_ff;
      was_on_in = was_on_ff;
      tim_in    = tim_ff;
      tsc_in    = tsc_ff;
      sc_in     = sc_ff;
      stored_in = stored_ff;
      fw_in     = 1'b0;
      fmhz_in   = cur_ff;
      tw_in     = 1'b0;
      ev_in     = fla_pkg::EV_NONE;
      if (!en_ff) begin
         was_on_in = 1'b0;
      end else begin
         if (!was_on_ff) begin
            was_on_in = 1'b1;
            mode_in   = fla_pkg::MODE_WARMUP;
            tim_in    = '0;
            sc_in     = '0;
            if (stored_ff != 16'd0) begin
               if (stored_ff > ceil_ff) begin
                  resumed = ceil_ff;
                  tw_in   = 1'b1;
               end
               stored_in = resumed;
               if (resumed != 16'd0 && resumed > cur_ff) begin
                  fw_in   = 1'b1;
                  fmhz_in = resumed;
                  ev_in   = fla_pkg::EV_RESUMED;
               end
            end
         end else begin
            tim_in = (tim_ff == 16'hFFFF) ? tim_ff : tim_ff + 16'd1;
            tsc_in = (tsc_ff == 16'hFFFF) ? tsc_ff : tsc_ff + 16'd1;
         end

         if (!self_test_ff && asic_rdy_ff) begin
            if (mode_in == fla_pkg::MODE_WARMUP) begin
               if (tim_in >= cfg.warmup_ticks) begin
                  mode_in = fla_pkg::MODE_CLIMB;
                  tsc_in  = '0;
                  sc_in   = '0;
                  ev_in   = fla_pkg::EV_WARM_DONE;
               end
            end else if (mode_in == fla_pkg::MODE_BACKOFF) begin
               if (tim_in >= cfg.cooldown_ticks) begin
                  mode_in = fla_pkg::MODE_CLIMB;
                  tsc_in  = '0;
                  sc_in   = '0;
                  ev_in   = fla_pkg::EV_COOL_DONE;
               end
            end else if (err_ff >= cfg.unstable_error_limit) begin
               if (have_below_ff) begin
                  fw_in     = 1'b1;
                  fmhz_in   = below_val_ff;
                  stored_in = below_val_ff;
                  tw_in     = 1'b1;
                  ev_in     = fla_pkg::EV_DOWN;
               end else begin
                  ev_in = fla_pkg::EV_FLOOR;
               end
               mode_in = fla_pkg::MODE_BACKOFF;
               tim_in  = '0;
               sc_in   = '0;
            end else begin
               if (!throttled_ff && err_ff < cfg.stable_error_limit) begin
                  if (sc_in < WINDOW) begin
                     sc_in = sc_in + 2'd1;
                  end
               end else begin
                  sc_in = '0;
               end
               if (sc_in >= WINDOW && tsc_in >= cfg.climb_interval_ticks) begin
                  if (have_next_ff) begin
                     fw_in     = 1'b1;
                     fmhz_in   = next_val_ff;
                     stored_in = next_val_ff;
                     tw_in     = 1'b1;
                     sc_in     = '0;
                     ev_in     = fla_pkg::EV_UP;
                  end else begin
                     ev_in = fla_pkg::EV_CEILING;
                  end
                  tsc_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= fla_pkg::MODE_WARMUP;
         was_on_ff <= 1'b0;
         tim_ff    <= '0;
         tsc_ff    <= '0;
         sc_ff     <= '0;
         stored_ff <= '0;
      end else if (cmd.commit) begin
         mode_ff   <= mode_in;
         was_on_ff <= was_on_in;
         tim_ff    <= tim_in;
         tsc_ff    <= tsc_in;
         sc_ff     <= sc_in;
         stored_ff <= stored_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         fw_ff       <= fw_in;
         fmhz_ff     <= fmhz_in;
         tw_ff       <= tw_in;
         mode_out_ff <= en_ff ? mode_in : fla_pkg::MODE_OFF;
         ev_ff       <= ev_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_freq_write  = fw_ff;
   assign rsp_freq_mhz    = fmhz_ff;
   assign rsp_tuned_write = tw_ff;
   assign rsp_tuned_mhz   = stored_ff;
   assign rsp_mode        = mode_out_ff;
   assign rsp_event_res   = ev_ff;

endmodule
`default_nettype wire

// ----- hdl/fla_ctrl.sv -----
// Controller: sequences capture, ladder scan and commit of one tick.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fla_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  fla_pkg::status_type  status,
   output fla_pkg::cmd_type     cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;

   logic [1:0] state_ff, state_in;

   assign req_ready     = (state_ff == S_IDLE);
   assign cmd.capture   = (state_ff == S_IDLE) && req_valid;
   assign cmd.scan_step = (state_ff == S_SCAN);
   assign cmd.commit    = (state_ff == S_DECIDE) && status.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (status.scan_last) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // hold until the result register can take the transfer
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_valid && req_ready, state_ff == S_SCAN)
   `ASSERT_NEXT(a_scan_ends, clock, reset, (state_ff == S_SCAN) && status.scan_last, state_ff == S_DECIDE)
   `ASSERT_NEXT(a_commit_frees, clock, reset, cmd.commit, req_ready && !cmd.scan_step)
   `ASSERT_SAME(a_no_step_while_idle, clock, reset, req_ready, !cmd.scan_step && !cmd.commit)

endmodule
`default_nettype wire

// ----- hdl/frequency_ladder_autotuner_core.sv -----
// Frequency ladder autotuner: top level joining registers, controller and datapath.
// Flow: the request transfer captures the tick, then the ladder is walked one preset per cycle;
// the decision is committed to the output register once that register is free, raising rsp_valid.
// A new tick is accepted only after the current one commits, so the serial ladder walk sets the rate.
// A pending result may wait in the output register while the next tick is taken and scanned.
// Reset: synchronous, active high; registers return to defaults, tuner enters warmup, nothing pending.
`timescale 1ns / 1ps
`default_nettype none
module frequency_ladder_autotuner_core #(
   parameter int MAX_PRESETS   = 12,
   parameter int STABLE_WINDOW = 3
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_enabled,
   input  wire logic                            req_self_test_active,
   input  wire logic                            req_asic_ready,
   input  wire logic                            req_voltage_throttling,
   input  wire logic                            req_thermal_throttling,
   input  wire logic [13:0]                     req_error_rate,
   input  wire logic [15:0]                     req_current_mhz,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_freq_write,
   output logic [15:0]                          rsp_freq_mhz,
   output logic                                 rsp_tuned_write,
   output logic [15:0]                          rsp_tuned_mhz,
   output logic [1:0]                           rsp_mode,
   output logic [2:0]                           rsp_event_res,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [fla_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [fla_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [fla_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   fla_pkg::cfg_type    cfg;
   fla_pkg::cmd_type    cmd;
   fla_pkg::status_type status;

   fla_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fla_dp #(
      .MAX_PRESETS   (MAX_PRESETS),
      .STABLE_WINDOW (STABLE_WINDOW)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg),
      .cmd                    (cmd),
      .status                 (status),
      .req_enabled            (req_enabled),
      .req_self_test_active   (req_self_test_active),
      .req_asic_ready         (req_asic_ready),
      .req_voltage_throttling (req_voltage_throttling),
      .req_thermal_throttling (req_thermal_throttling),
      .req_error_rate         (req_error_rate),
      .req_current_mhz        (req_current_mhz),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_freq_write         (rsp_freq_write),
      .rsp_freq_mhz           (rsp_freq_mhz),
      .rsp_tuned_write        (rsp_tuned_write),
      .rsp_tuned_mhz          (rsp_tuned_mhz),
      .rsp_mode               (rsp_mode),
      .rsp_event_res          (rsp_event_res)
   );

endmodule
`default_nettype wire
